// ----- sv/quaternion_to_euler_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angle block
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_MACROS_SVH
`define QUATERNION_TO_EULER_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define QTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg
// Widths, constants, the arctangent table and the types shared by the
// quaternion to Euler angle block.
// ----------------------------------------------------------------------------
package qte_pkg;

  // Quaternion parts are Q1.14; products land exactly on 28 fraction bits.
  localparam int QuatWidth   = 16;
  localparam int ProdW       = 2 * QuatWidth;
  localparam int TermW       = 36;
  localparam int OneShift    = 28;
  localparam int MagW        = 28;
  localparam int RemW        = 57;
  localparam int RootW       = 29;
  localparam int CordW       = 38;
  localparam int AccW        = 27;
  localparam int AngW        = 16;
  localparam int PitchW      = 15;
  localparam int CordicSteps = 16;
  localparam int CordicLat   = CordicSteps + 2;

  localparam int RollLim  = 23040;
  localparam int PitchLim = 11520;
  localparam int Deg180   = 180 * 65536;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;

  // atan(2^-i) in degrees with 16 fraction bits, rounded to nearest.
  function automatic logic signed [AccW-1:0] atan_entry(input int unsigned i);
    logic signed [AccW-1:0] v;
    case (i)
      0:       v = AccW'(2949120);
      1:       v = AccW'(1740967);
      2:       v = AccW'(919879);
      3:       v = AccW'(466945);
      4:       v = AccW'(234379);
      5:       v = AccW'(117303);
      6:       v = AccW'(58666);
      7:       v = AccW'(29335);
      8:       v = AccW'(14668);
      9:       v = AccW'(7334);
      10:      v = AccW'(3667);
      11:      v = AccW'(1833);
      12:      v = AccW'(917);
      13:      v = AccW'(458);
      14:      v = AccW'(229);
      15:      v = AccW'(115);
      16:      v = AccW'(57);
      17:      v = AccW'(29);
      18:      v = AccW'(14);
      19:      v = AccW'(7);
      20:      v = AccW'(4);
      21:      v = AccW'(2);
      22:      v = AccW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // One classified request as it waits between the front and back parts.
  typedef struct packed {
    logic signed [TermW-1:0] sr;
    logic signed [TermW-1:0] cr;
    logic signed [TermW-1:0] sp;
    logic signed [TermW-1:0] sy;
    logic signed [TermW-1:0] cy;
    logic [RemW-1:0]         rem;
    logic                    sat_pos;
    logic                    sat_neg;
  } qte_item_t;

  // Queue status seen by the front part and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } qte_qstat_t;

endpackage

// ----- sv/qte_front.sv -----
// ----------------------------------------------------------------------------
// qte_front
// Front part: forms the ZYX product terms, classifies the pitch term as
// saturated or not and prepares the radicand for the pitch cosine.
// ----------------------------------------------------------------------------
module qte_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic signed [qte_pkg::QuatWidth-1:0]   quat_w_i,
  input  logic signed [qte_pkg::QuatWidth-1:0]   quat_x_i,
  input  logic signed [qte_pkg::QuatWidth-1:0]   quat_y_i,
  input  logic signed [qte_pkg::QuatWidth-1:0]   quat_z_i,
  input  qte_pkg::qte_qstat_t                    qstat_i,
  output logic                                   in_ready_o,
  output logic                                   push_o,
  output qte_pkg::qte_item_t                     item_o
);
  import qte_pkg::*;

  localparam logic signed [TermW-1:0] One = TermW'(1) <<< OneShift;

  logic                    adv;
  logic [2:0]              valid_q;
  logic signed [ProdW-1:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wy_q;
  logic signed [ProdW-1:0] p_zx_q, p_wz_q, p_xy_q, p_zz_q;
  qte_item_t               s2_d, s2_q, s3_q;
  logic signed [TermW-1:0] sp_abs;
  logic [MagW-1:0]         mag_d, mag_q;
  logic [2*MagW-1:0]       msq_q;

  // The whole front moves together while the queue has room.
  assign adv        = !qstat_i.full;
  assign in_ready_o = adv;
  assign push_o     = adv && valid_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[1:0], in_valid_i};
    end
  end

  // Stage one: the nine products.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_wx_q <= quat_w_i * quat_x_i;
      p_yz_q <= quat_y_i * quat_z_i;
      p_xx_q <= quat_x_i * quat_x_i;
      p_yy_q <= quat_y_i * quat_y_i;
      p_wy_q <= quat_w_i * quat_y_i;
      p_zx_q <= quat_z_i * quat_x_i;
      p_wz_q <= quat_w_i * quat_z_i;
      p_xy_q <= quat_x_i * quat_y_i;
      p_zz_q <= quat_z_i * quat_z_i;
    end
  end

  // Stage two: sine and cosine terms and the pitch classification.
  always_comb begin
    s2_d         = '0;
    s2_d.sr      = (TermW'(p_wx_q) + TermW'(p_yz_q)) <<< 1;
    s2_d.cr      = One - ((TermW'(p_xx_q) + TermW'(p_yy_q)) <<< 1);
    s2_d.sp      = (TermW'(p_wy_q) - TermW'(p_zx_q)) <<< 1;
    s2_d.sy      = (TermW'(p_wz_q) + TermW'(p_xy_q)) <<< 1;
    s2_d.cy      = One - ((TermW'(p_yy_q) + TermW'(p_zz_q)) <<< 1);
    s2_d.sat_pos = s2_d.sp >= One;
    s2_d.sat_neg = s2_d.sp <= -One;
    sp_abs       = s2_d.sp[TermW-1] ? -s2_d.sp : s2_d.sp;
    mag_d        = sp_abs[MagW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q  <= s2_d;
      mag_q <= mag_d;
    end
  end

  // Stage three: square of the pitch sine magnitude.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q  <= s2_q;
      msq_q <= mag_q * mag_q;
    end
  end

  // Radicand for the cosine: one minus the sine squared at 56 fraction bits.
  always_comb begin
    item_o     = s3_q;
    item_o.rem = (RemW'(1) << (2 * OneShift)) - RemW'(msq_q);
  end

endmodule

// ----- sv/qte_queue.sv -----
// ----------------------------------------------------------------------------
// qte_queue
// Short first-in first-out queue of classified requests between the front
// and back parts, with the head shown ahead of the pop.
// ----------------------------------------------------------------------------
module qte_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  qte_pkg::qte_item_t   item_i,
  input  logic                 pop_i,
  output qte_pkg::qte_item_t   head_o,
  output qte_pkg::qte_qstat_t  qstat_o
);
  import qte_pkg::*;

  qte_item_t        mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign qstat_o.full  = count_q == (QPtrW + 1)'(QueueDepth);
  assign qstat_o.empty = count_q == '0;
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- sv/qte_cordic.sv -----
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC for atan2 in degrees, with conversion to
// 1/128 degree, clamping and an optional forced saturation.
// ----------------------------------------------------------------------------
module qte_cordic (
  input  logic                               clk_i,
  input  logic                               adv_i,
  input  logic signed [qte_pkg::TermW-1:0]   y_i,
  input  logic signed [qte_pkg::TermW-1:0]   x_i,
  input  logic                               sat_pos_i,
  input  logic                               sat_neg_i,
  input  logic [qte_pkg::AngW-1:0]           lim_i,
  output logic signed [qte_pkg::AngW-1:0]    angle_o
);
  import qte_pkg::*;

  logic signed [CordW-1:0] x_q [CordicSteps+1];
  logic signed [CordW-1:0] y_q [CordicSteps+1];
  logic signed [AccW-1:0]  z_q [CordicSteps+1];
  logic                    zero_q [CordicSteps+1];
  logic                    satp_q [CordicSteps+1];
  logic                    satn_q [CordicSteps+1];
  logic signed [CordW-1:0] xe, ye;
  logic signed [AccW-1:0]  acc, rnd, lim_s, ang;

  assign xe = CordW'(x_i);
  assign ye = CordW'(y_i);

  // Pre-rotation: fold the left half plane onto the right one.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      satp_q[0] <= sat_pos_i;
      satn_q[0] <= sat_neg_i;
      if (x_i[TermW-1]) begin
        x_q[0] <= -xe;
        y_q[0] <= -ye;
        z_q[0] <= y_i[TermW-1] ? -AccW'(Deg180) : AccW'(Deg180);
      end else begin
        x_q[0] <= xe;
        y_q[0] <= ye;
        z_q[0] <= '0;
      end
    end
  end

  // Micro-rotations, one per stage.
  for (genvar j = 0; j < CordicSteps; j++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        zero_q[j+1] <= zero_q[j];
        satp_q[j+1] <= satp_q[j];
        satn_q[j+1] <= satn_q[j];
        if (!y_q[j][CordW-1]) begin
          x_q[j+1] <= x_q[j] + (y_q[j] >>> j);
          y_q[j+1] <= y_q[j] - (x_q[j] >>> j);
          z_q[j+1] <= z_q[j] + atan_entry(j);
        end else begin
          x_q[j+1] <= x_q[j] - (y_q[j] >>> j);
          y_q[j+1] <= y_q[j] + (x_q[j] >>> j);
          z_q[j+1] <= z_q[j] - atan_entry(j);
        end
      end
    end
  end

  // Round to 1/128 degree and clamp.
  always_comb begin
    acc   = zero_q[CordicSteps] ? '0 : z_q[CordicSteps];
    rnd   = (acc + AccW'(256)) >>> 9;
    lim_s = AccW'(lim_i);
    if (satp_q[CordicSteps]) begin
      ang = lim_s;
    end else if (satn_q[CordicSteps]) begin
      ang = -lim_s;
    end else if (rnd > lim_s) begin
      ang = lim_s;
    end else if (rnd < -lim_s) begin
      ang = -lim_s;
    end else begin
      ang = rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      angle_o <= ang[AngW-1:0];
    end
  end

endmodule

// ----- sv/qte_back.sv -----
// ----------------------------------------------------------------------------
// qte_back
// Back part: bit-per-stage square root for the pitch cosine, then three
// CORDIC pipelines for roll, pitch and yaw, ending in the output register.
// ----------------------------------------------------------------------------
module qte_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  qte_pkg::qte_item_t                 head_i,
  input  logic                               head_valid_i,
  input  logic                               out_ready_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  output logic signed [qte_pkg::AngW-1:0]    roll_o,
  output logic signed [qte_pkg::AngW-1:0]    yaw_o,
  output logic signed [qte_pkg::PitchW-1:0]  pitch_o
);
  import qte_pkg::*;

  localparam int NStage = RootW + CordicLat;
  localparam int TW     = RemW + 2;

  logic              adv;
  logic [NStage-1:0] valid_q;
  qte_item_t         item_q [RootW];
  logic [RemW-1:0]   rem_q  [RootW];
  logic [RootW-1:0]  root_q [RootW];
  logic signed [TermW-1:0] cos_p;
  logic signed [AngW-1:0]  pitch_full;

  // The back moves whenever the output register is free or being taken.
  assign adv         = !valid_q[NStage-1] || out_ready_i;
  assign pop_o       = adv && head_valid_i;
  assign out_valid_o = valid_q[NStage-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NStage-2:0], head_valid_i};
    end
  end

  // Square root, one result bit per stage from the top bit down.
  for (genvar s = 0; s < RootW; s++) begin : g_sqrt
    localparam int K = RootW - 1 - s;
    qte_item_t        it_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [TW-1:0]    trial;

    if (s == 0) begin : g_first
      assign it_in   = head_i;
      assign rem_in  = head_i.rem;
      assign root_in = '0;
    end else begin : g_next
      assign it_in   = item_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        item_q[s] <= it_in;
        if (TW'(rem_in) >= trial) begin
          rem_q[s]  <= rem_in - trial[RemW-1:0];
          root_q[s] <= root_in | (RootW'(1) << K);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign cos_p = $signed(TermW'(root_q[RootW-1]));

  // Angle pipelines.
  qte_cordic u_roll (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .y_i       (item_q[RootW-1].sr),
    .x_i       (item_q[RootW-1].cr),
    .sat_pos_i (1'b0),
    .sat_neg_i (1'b0),
    .lim_i     (AngW'(RollLim)),
    .angle_o   (roll_o)
  );

  qte_cordic u_pitch (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .y_i       (item_q[RootW-1].sp),
    .x_i       (cos_p),
    .sat_pos_i (item_q[RootW-1].sat_pos),
    .sat_neg_i (item_q[RootW-1].sat_neg),
    .lim_i     (AngW'(PitchLim)),
    .angle_o   (pitch_full)
  );

  qte_cordic u_yaw (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .y_i       (item_q[RootW-1].sy),
    .x_i       (item_q[RootW-1].cy),
    .sat_pos_i (1'b0),
    .sat_neg_i (1'b0),
    .lim_i     (AngW'(RollLim)),
    .angle_o   (yaw_o)
  );

  assign pitch_o = pitch_full[PitchW-1:0];

endmodule

// ----- sv/quaternion_to_euler.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler
// ZYX Euler angles (roll, pitch, yaw) from a Q1.14 quaternion stream.
// ----------------------------------------------------------------------------
// Takes one quaternion request per clock and returns roll, pitch and yaw in
// signed units of 1/128 degree, one result per request in order. The path has
// 3 front stages that form the products and the pitch radicand, the 4-entry
// queue, 29 square-root stages (one root bit each), then 16 CORDIC stages plus
// one pre-rotation and one output register. Throughput is one quaternion per
// cycle; the output stall stops the back pipeline and the queue lets the front
// keep accepting until it fills.
// Pitch saturates to +/-90 degrees when |2(wy - zx)| reaches one.
`include "quaternion_to_euler_macros.svh"

module quaternion_to_euler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // roll_angle [15:0], pitch_angle [30:16], yaw_angle [46:31], zero [47]
  output logic [47:0] m_axis_tdata_o
);
  import qte_pkg::*;

  logic                     push, pop;
  qte_item_t                front_item, head_item;
  qte_qstat_t               qstat;
  logic signed [AngW-1:0]   roll, yaw;
  logic signed [PitchW-1:0] pitch;
  logic                     pitch_ok, roll_yaw_ok;

  qte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .quat_w_i   ($signed(s_axis_tdata_i[15:0])),
    .quat_x_i   ($signed(s_axis_tdata_i[31:16])),
    .quat_y_i   ($signed(s_axis_tdata_i[47:32])),
    .quat_z_i   ($signed(s_axis_tdata_i[63:48])),
    .qstat_i    (qstat),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .item_o     (front_item)
  );

  qte_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .qstat_o (qstat)
  );

  qte_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_item),
    .head_valid_i (!qstat.empty),
    .out_ready_i  (m_axis_tready_i),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .roll_o       (roll),
    .yaw_o        (yaw),
    .pitch_o      (pitch)
  );

  assign m_axis_tdata_o = {1'b0, yaw, pitch, roll};

  // Range flags for the angle checks.
  assign pitch_ok    = (pitch <= PitchW'(PitchLim)) && (pitch >= -PitchW'(PitchLim));
  assign roll_yaw_ok = (roll <= AngW'(RollLim)) && (roll >= -AngW'(RollLim)) &&
                       (yaw <= AngW'(RollLim)) && (yaw >= -AngW'(RollLim));

  // Checks on the front, queue and angle ranges.
  `QTE_ASSERT_NOW(a_stall_means_full, !s_axis_tready_o, qstat.full, "front stalled, queue not full")
  `QTE_ASSERT_NOW(a_queue_status, qstat.full, !qstat.empty, "queue full and empty at once")
  `QTE_ASSERT_NOW(a_pitch_range, m_axis_tvalid_o, pitch_ok, "pitch out of range")
  `QTE_ASSERT_NOW(a_roll_yaw_range, m_axis_tvalid_o, roll_yaw_ok, "roll or yaw out of range")

endmodule

// ----- bench/qte_checker.sv -----
// ----------------------------------------------------------------------------
// qte_checker
// Watches both streams of the quaternion to Euler block, predicts the angles
// for every accepted request and compares each accepted result in order.
// ----------------------------------------------------------------------------
module qte_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [63:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  angles_t angle_q[$];

  // Arctangent table in degrees with 16 fraction bits.
  function automatic longint atan_deg(input int i);
    longint tab[23] = '{2949120, 1740967, 919879, 466945, 234379, 117303, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                        29, 14, 7, 4, 2, 1};
    return (i < 23) ? tab[i] : 0;
  endfunction

  // Vectoring CORDIC arctangent; >>> on longint floors.
  function automatic longint vec_atan2(input longint yy, input longint xx);
    longint acc, xs, ys, xv, yv;
    acc = 0;
    xv = xx;
    yv = yy;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      acc = (yv >= 0) ? (64'sd180 <<< 16) : -(64'sd180 <<< 16);
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < 16; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys; yv = yv - xs; acc = acc + atan_deg(i);
      end else begin
        xv = xv - ys; yv = yv + xs; acc = acc - atan_deg(i);
      end
    end
    return acc;
  endfunction

  function automatic longint to_units(input longint acc, input longint lim);
    longint v;
    v = (acc + 256) >>> 9;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic longint int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // Products of Q1.14 parts already carry 28 fraction bits.
  function automatic angles_t euler_of(input logic [63:0] d);
    longint w, x, y, z, sr, cr, sp, sy, cy, c, one;
    logic [63:0] mag;
    angles_t a;
    w = longint'($signed(d[15:0]));
    x = longint'($signed(d[31:16]));
    y = longint'($signed(d[47:32]));
    z = longint'($signed(d[63:48]));
    one = 64'sd1 <<< 28;
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    a.roll = 16'(to_units(vec_atan2(sr, cr), 23040));
    if (sp >= one) a.pitch = 15'sd11520;
    else if (sp <= -one) a.pitch = -15'sd11520;
    else begin
      mag = (sp < 0) ? -sp : sp;
      c = int_sqrt((64'd1 << 56) - mag * mag);
      a.pitch = 15'(to_units(vec_atan2(sp, c), 11520));
    end
    a.yaw = 16'(to_units(vec_atan2(sy, cy), 23040));
    return a;
  endfunction

  int fails;
  assign fail_count_o = fails;
  assign pending_o    = angle_q.size();

  // Predict on accepted requests, compare on accepted results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    angles_t got, want;
    if (!rst_ni) begin
      fails <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) angle_q = {angle_q, euler_of(s_axis_tdata_i)};
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.roll  = m_axis_tdata_i[15:0];
        got.pitch = m_axis_tdata_i[30:16];
        got.yaw   = m_axis_tdata_i[46:31];
        if (angle_q.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10) $display("Unexpected result %h", m_axis_tdata_i);
        end else begin
          want = angle_q.pop_front();
          if (got != want || m_axis_tdata_i[47] !== 1'b0) begin
            fails <= fails + 1;
            if (fails < 10)
              $display("Mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/act)",
                       want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw);
          end
        end
      end
    end
  end

endmodule

// ----- bench/tb_quaternion_to_euler.sv -----
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler
// Drives directed and random quaternion requests under varying back-pressure
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  int          fail_count, pending;
  int          send_idle = 36, recv_idle = 58;
  longint      cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  quaternion_to_euler u_top (.*);

  qte_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stalls at random.
  always @(negedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= recv_idle);

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one request, idling first, and holds it until accepted.
  task automatic send_quat(input logic [63:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_part();
    int u;
    u = int'($urandom_range(9));
    if (u == 0) return 16'($urandom);
    if (u == 1) return 16'h4000;
    if (u == 2) return 16'hC000;
    return 16'($signed(int'($urandom_range(32768)) - 16384));
  endfunction

  // Random quaternion: each part drawn and shifted right by one bit, or in one draw of ten the whole word at random.
  function automatic logic [63:0] rand_quat();
    logic [15:0] p;
    p = rand_part();
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    return {rand_part() >>> 1, p >>> 1, rand_part() >>> 1, rand_part() >>> 1};
  endfunction

  logic [63:0] directed[$] = '{
    64'h0, {16'h0, 16'h0, 16'h0, 16'h4000}, {16'h0, 16'h0, 16'h0, 16'hC000},
    {16'h8000, 16'h8000, 16'h8000, 16'h8000}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
    {16'h0, 16'h0, 16'h4000, 16'h0}, {16'h0, 16'h4000, 16'h0, 16'h0},
    {16'h4000, 16'h0, 16'h0, 16'h0}, {16'h0, 16'h2D41, 16'h0, 16'h2D41},
    {16'h0, 16'hD2BF, 16'h0, 16'h2D41}, {16'h0, 16'h2D42, 16'h0, 16'h2D42},
    {16'h2000, 16'h2000, 16'h2000, 16'h2000}, {16'hE000, 16'h2000, 16'hE000, 16'h2000},
    {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF, 16'h0, 16'h7FFF},
    {16'h0, 16'hFFFF, 16'h1, 16'h4000}, {16'h1, 16'h0, 16'hFFFF, 16'h4000},
    {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}
  };

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_quat(directed[i]);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 36 : (ph == 1) ? 58 : 0;
      recv_idle = (ph == 0) ? 58 : (ph == 1) ? 36 : 0;
      for (int n = 0; n < 300; n++) begin
        send_quat(rand_quat());
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
